@@ src/frbpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frbpm_pkg
// Shared types and codes for the frame buffer pool manager.
// ----------------------------------------------------------------------------
package frbpm_pkg;

    // defaults for the top-level parameters
    localparam int NUM_BUFFERS_DEF = 8;
    localparam int BUS_SLOTS_DEF   = 2;
    localparam int MAX_READERS_DEF = 15;

    // field widths
    localparam int ACT_W    = 3;
    localparam int IDX_W    = 3;
    localparam int KIND_W   = 3;
    localparam int CNT32_W  = 32;
    localparam int LOCK_W   = 5;

    // action codes
    localparam logic [ACT_W-1:0] ACT_START   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_STOP    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FRAME   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_GET     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] K_PLACED   = 3'd0;
    localparam logic [KIND_W-1:0] K_GRANTED  = 3'd1;
    localparam logic [KIND_W-1:0] K_NOFREE   = 3'd2;
    localparam logic [KIND_W-1:0] K_NONE     = 3'd3;
    localparam logic [KIND_W-1:0] K_NOTREADY = 3'd4;
    localparam logic [KIND_W-1:0] K_ACK      = 3'd5;
    localparam logic [KIND_W-1:0] K_BADREL   = 3'd6;

    // lock count values
    localparam logic signed [LOCK_W-1:0] LOCK_BUS  = -5'sd1;
    localparam logic signed [LOCK_W-1:0] LOCK_FREE = 5'sd0;

    localparam logic [CNT32_W-1:0] CNT32_MAX = '1;

    // one buffer descriptor as held in the pool memory
    typedef struct packed {
        logic signed [LOCK_W-1:0] lock;
        logic [CNT32_W-1:0]       stamp;
        logic                     rd;
    } t_entry;

    localparam t_entry ENTRY_RST = '{lock: LOCK_FREE, stamp: '0, rd: 1'b1};

endpackage

@@ src/frame_buffer_pool_manager_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_buffer_pool_manager_unit
// Reference-counted pool of frame buffers feeding a capture bus and readers.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit first)                  | tuser     | tlast
//  s_axis   | in  | buffer_index[3], frame_ok, wait_new, 0 | action[3] | -
//  m_axis   | out | buffer_id[3], frames_captured[32], 0   | kind[3]   | last
//
//  Descriptors live in one memory with a registered read; each search reads
//  every entry once and ends in one result beat. Start runs BUS_SLOTS
//  searches, get one when running, frame done one when running and the buffer
//  was on the bus, after a read-modify-write of that entry; stop and the other
//  actions run none. Reset clears per-entry valid bits at once; no clearing pass.
//  A held result does not block input; the next result waits for it.
// ----------------------------------------------------------------------------
module frame_buffer_pool_manager_unit
    import frbpm_pkg::*;
#(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
    parameter int BUS_SLOTS   = BUS_SLOTS_DEF,
    parameter int MAX_READERS = MAX_READERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // buffer_index[2:0], frame_ok[3], wait_new[4], zero
    input  logic [2:0]  s_axis_tuser,   // action[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // buffer_id[2:0], frames_captured[34:3], zero
    output logic [2:0]  m_axis_tuser,   // kind[2:0]
    output logic        m_axis_tlast
);

    localparam int IW = $clog2(NUM_BUFFERS);
    localparam int CW = $clog2(NUM_BUFFERS + 1);
    localparam int SW = $clog2(BUS_SLOTS + 1);
    localparam logic [CW-1:0] CNT_END = CW'(NUM_BUFFERS);
    localparam logic [SW-1:0] SLOT_LAST = SW'(BUS_SLOTS - 1);
    localparam logic signed [LOCK_W-1:0] LOCK_MAX = LOCK_W'(MAX_READERS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_SCAN,
        S_PICK,
        S_EMIT
    } t_state;

    t_state r_state;

    // latched item
    logic [ACT_W-1:0] r_act;
    logic [IDX_W-1:0] r_idx;
    logic             r_ok;
    logic             r_wait;

    // search
    logic          r_get;
    logic [CW-1:0] r_cnt;
    logic          r_pend;
    logic [IW-1:0] r_pidx;
    logic          r_found;
    logic [IW-1:0] r_best;
    t_entry        r_best_e;
    logic [SW-1:0] r_slot;

    // pending result
    logic [KIND_W-1:0] r_res_kind;
    logic [IDX_W-1:0]  r_res_id;
    logic              r_res_last;

    // globals
    logic               r_running;
    logic               r_overflow;
    logic [CNT32_W-1:0] r_stamp_cnt;
    logic [CNT32_W-1:0] r_good;

    // output register
    logic               r_m_valid;
    logic [KIND_W-1:0]  r_m_kind;
    logic [IDX_W-1:0]   r_m_id;
    logic               r_m_last;
    logic [CNT32_W-1:0] r_m_frames;

    // pool memory
    t_entry           mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] r_vld;
    t_entry           r_rd_raw;
    logic             r_rd_v;
    t_entry           rd_e;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;

    logic [ACT_W-1:0] s_act;
    logic [IDX_W-1:0] s_idx;
    logic             s_accept;
    logic             s_idx_in;

    logic               chk_bad;
    logic               chk_requeue;
    logic signed [LOCK_W-1:0] chk_lock_dec;
    logic [CNT32_W-1:0] stamp_next;
    logic [CNT32_W-1:0] good_next;
    logic               pick_grant;
    logic               scan_take;

    assign s_act    = s_axis_tuser;
    assign s_idx    = s_axis_tdata[2:0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign s_idx_in = 32'(s_idx) < 32'(NUM_BUFFERS);

    assign rd_e = r_rd_v ? r_rd_raw : ENTRY_RST;

    assign stamp_next = (r_stamp_cnt == CNT32_MAX) ? r_stamp_cnt : r_stamp_cnt + 1'b1;
    assign good_next  = (r_good == CNT32_MAX) ? r_good : r_good + 1'b1;

    assign chk_lock_dec = rd_e.lock - 5'sd1;
    assign chk_bad      = (r_act == ACT_FRAME) ? (rd_e.lock != LOCK_BUS)
                                               : (rd_e.lock <= LOCK_FREE);
    assign chk_requeue  = r_overflow && (chk_lock_dec == LOCK_FREE);
    assign pick_grant   = r_found && !(r_wait && r_best_e.rd);

    // newest off-bus buffer for a grant, oldest free one for a placement
    assign scan_take = r_get
        ? (!rd_e.lock[LOCK_W-1] && (!r_found || rd_e.stamp > r_best_e.stamp))
        : ((rd_e.lock == LOCK_FREE) && (!r_found || rd_e.stamp < r_best_e.stamp));

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = IW'(s_idx);
        wr_en   = 1'b0;
        wr_addr = IW'(r_idx);
        wr_data = rd_e;
        unique case (r_state)
            S_IDLE: begin
                rd_en = s_accept && s_idx_in;
            end
            S_SCAN: begin
                rd_en   = (r_cnt != CNT_END);
                rd_addr = IW'(r_cnt);
            end
            S_CHK: begin
                wr_en = !chk_bad;
                if (r_act == ACT_FRAME) begin
                    wr_data.lock  = LOCK_FREE;
                    wr_data.stamp = r_ok ? stamp_next : rd_e.stamp;
                    wr_data.rd    = !r_ok;
                end else begin
                    wr_data.lock = chk_requeue ? LOCK_BUS : chk_lock_dec;
                end
            end
            S_PICK: begin
                wr_addr = r_best;
                wr_data = r_best_e;
                if (r_get) begin
                    wr_en = pick_grant;
                    wr_data.lock = (r_best_e.lock < LOCK_MAX) ? r_best_e.lock + 5'sd1
                                                              : r_best_e.lock;
                    wr_data.rd = 1'b1;
                end else begin
                    wr_en = r_found;
                    wr_data.lock = LOCK_BUS;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_raw <= mem[rd_addr];
        end
    end

    // an entry never written reads as its reset descriptor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rd_v <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_v <= r_vld[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= 1'b0;
            r_overflow  <= 1'b0;
            r_stamp_cnt <= '0;
            r_good      <= '0;
            r_m_valid   <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready && (r_state != S_EMIT)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_act      <= s_act;
                        r_idx      <= s_idx;
                        r_ok       <= s_axis_tdata[3];
                        r_wait     <= s_axis_tdata[4];
                        r_slot     <= '0;
                        r_cnt      <= '0;
                        r_found    <= 1'b0;
                        r_res_id   <= '0;
                        r_res_last <= 1'b1;
                        unique case (s_act)
                            ACT_START: begin
                                r_overflow <= 1'b0;
                                r_good     <= '0;
                                r_running  <= 1'b1;
                                r_get      <= 1'b0;
                                r_res_kind <= K_ACK;
                                r_state    <= S_SCAN;
                            end
                            ACT_STOP: begin
                                r_running  <= 1'b0;
                                r_res_kind <= K_ACK;
                                r_state    <= S_EMIT;
                            end
                            ACT_FRAME: begin
                                r_res_kind <= K_ACK;
                                r_state    <= s_idx_in ? S_CHK : S_EMIT;
                            end
                            ACT_GET: begin
                                r_get <= 1'b1;
                                if (r_running) begin
                                    r_res_kind <= K_ACK;
                                    r_state    <= S_SCAN;
                                end else begin
                                    r_res_kind <= K_NONE;
                                    r_state    <= S_EMIT;
                                end
                            end
                            ACT_RELEASE: begin
                                if (s_idx_in) begin
                                    r_res_kind <= K_ACK;
                                    r_state    <= S_CHK;
                                end else begin
                                    r_res_kind <= K_BADREL;
                                    r_state    <= S_EMIT;
                                end
                            end
                            default: begin
                                r_res_kind <= K_ACK;
                                r_state    <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_CHK: begin
                    if (r_act == ACT_FRAME) begin
                        if (chk_bad || !r_running) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_get   <= 1'b0;
                            r_state <= S_SCAN;
                        end
                        if (!chk_bad && r_ok) begin
                            r_stamp_cnt <= stamp_next;
                            r_good      <= good_next;
                        end
                    end else begin
                        r_state <= S_EMIT;
                        if (chk_bad) begin
                            r_res_kind <= K_BADREL;
                        end else if (chk_requeue) begin
                            r_overflow <= 1'b0;
                            r_res_kind <= K_PLACED;
                            r_res_id   <= r_idx;
                        end
                    end
                end
                S_SCAN: begin
                    // r_pend marks read data arriving for entry r_pidx
                    r_pend <= (r_cnt != CNT_END);
                    if (r_cnt != CNT_END) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_pidx <= IW'(r_cnt);
                    end else if (!r_pend) begin
                        r_state <= S_PICK;
                    end
                    if (r_pend && scan_take) begin
                        r_found  <= 1'b1;
                        r_best   <= r_pidx;
                        r_best_e <= rd_e;
                    end
                end
                S_PICK: begin
                    r_state    <= S_EMIT;
                    r_res_last <= (r_act != ACT_START) || (r_slot == SLOT_LAST);
                    if (r_get) begin
                        if (!r_found) begin
                            r_res_kind <= K_NONE;
                            r_res_id   <= '0;
                        end else if (!pick_grant) begin
                            r_res_kind <= K_NOTREADY;
                            r_res_id   <= '0;
                        end else begin
                            r_res_kind <= K_GRANTED;
                            r_res_id   <= IDX_W'(r_best);
                        end
                    end else if (r_found) begin
                        r_res_kind <= K_PLACED;
                        r_res_id   <= IDX_W'(r_best);
                    end else begin
                        r_overflow <= 1'b1;
                        r_res_kind <= K_NOFREE;
                        r_res_id   <= '0;
                    end
                end
                S_EMIT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid  <= 1'b1;
                        r_m_kind   <= r_res_kind;
                        r_m_id     <= r_res_id;
                        r_m_last   <= r_res_last;
                        r_m_frames <= r_good;
                        if (r_res_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            // next bus slot of a start
                            r_slot  <= r_slot + 1'b1;
                            r_cnt   <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {5'b0, r_m_frames, r_m_id};
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tlast  = r_m_last;

endmodule

@@ src/frbpm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frbpm_checker
// Port-level checks on the frame buffer pool manager result stream.
// ----------------------------------------------------------------------------
module frbpm_checker
    import frbpm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a waiting input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata)
            && $stable(s_axis_tuser))
        else $error("input beat changed while waiting");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // buffer id only carried by placements and grants
    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != K_PLACED && m_axis_tuser != K_GRANTED
            |-> m_axis_tdata[2:0] == 3'd0)
        else $error("buffer id set on a result without a buffer");

    // only start yields more than one result, and start only places or reports no free buffer
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == K_GRANTED || m_axis_tuser == K_NONE
            || m_axis_tuser == K_NOTREADY || m_axis_tuser == K_BADREL
            || m_axis_tuser == K_ACK) |-> m_axis_tlast)
        else $error("single-result kind without tlast");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind frame_buffer_pool_manager_unit frbpm_checker u_frbpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
